// ===== design/bba_pkg.sv =====
// Shared types, codes and defaults for the buddy block allocator.
// No dependencies.
`timescale 1ns / 1ps

package bba_pkg;

    localparam int POOL_ORDER_DEF   = 16;
    localparam int HEADER_BYTES_DEF = 32;
    localparam int GRAIN_ORDER_DEF  = 6;

    localparam int ENTRY_W  = 7;
    localparam int HEAD_POS = 6;
    localparam int FREE_POS = 5;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_NOMEM  = 2'd2;

    typedef struct packed {
        logic        op;
        logic [16:0] request_bytes;
        logic [15:0] release_address;
    } t_bba_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] data_address;
    } t_bba_out;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ORDER, S_SCAN_RD, S_SCAN_CK, S_SPLIT,
        S_REL_RD, S_REL_CK, S_BUD_RD, S_BUD_CK, S_MARK, S_DONE
    } t_bba_state;

endpackage

// ===== design/bba_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bba_ctrl.sv =====
// Allocator sequencer: clears, scans, splits and merges in the block table.
// Depends on bba_pkg; drives the table RAM ports.
`timescale 1ns / 1ps

module bba_ctrl import bba_pkg::*; #(
    parameter int POOL_ORDER   = POOL_ORDER_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int GRAIN_ORDER  = GRAIN_ORDER_DEF,
    localparam int IW = POOL_ORDER - GRAIN_ORDER
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_bba_in            i_in_data,
    output logic               o_res_valid,
    input  logic               i_res_free,
    output t_bba_out           o_res_data,
    output logic               o_we,
    output logic [IW-1:0]      o_waddr,
    output logic [ENTRY_W-1:0] o_wdata,
    output logic [IW-1:0]      o_raddr,
    input  logic [ENTRY_W-1:0] i_rdata
);

    t_bba_state r_state, n_state;
    t_bba_in    r_in, n_in;
    t_bba_out   r_res, n_res;
    logic [IW:0]   r_idx, n_idx;
    logic [IW-1:0] r_hit, n_hit;
    logic [4:0]    r_k, n_k;
    logic [4:0]    r_need, n_need;
    logic          r_found, n_found;

    logic [IW:0]   one_w, step, e_step;
    logic [4:0]    e_ord;
    logic          e_head, e_free;
    logic [17:0]   need;
    logic [4:0]    calc_ord;
    logic          calc_ok;
    logic [24:0]   off;
    logic [IW-1:0] bidx;
    logic [31:0]   data_addr;

    assign one_w  = {{IW{1'b0}}, 1'b1};
    assign e_ord  = i_rdata[4:0];
    assign e_head = i_rdata[HEAD_POS];
    assign e_free = i_rdata[FREE_POS];
    assign e_step = one_w << (e_ord - 5'(GRAIN_ORDER));
    assign step   = one_w << (r_k - 5'(GRAIN_ORDER));
    assign need   = 18'(r_in.request_bytes) + 18'(HEADER_BYTES);
    assign off    = 25'(r_in.release_address) - 25'(HEADER_BYTES);
    assign bidx   = r_idx[IW-1:0] ^ step[IW-1:0];
    assign data_addr = (32'(r_hit) << GRAIN_ORDER) + 32'(HEADER_BYTES);

    // smallest order at or above grain size that holds request plus header
    always_comb begin
        calc_ord = 5'(POOL_ORDER);
        calc_ok  = 1'b0;
        for (int o = 24; o >= 0; o--) begin
            if (o >= GRAIN_ORDER && o <= POOL_ORDER && (33'd1 << o) >= 33'(need)) begin
                calc_ord = 5'(o);
                calc_ok  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_found <= n_found;
        end
        r_in   <= n_in;
        r_res  <= n_res;
        r_hit  <= n_hit;
        r_k    <= n_k;
        r_need <= n_need;
    end

    always_comb begin
        n_state = r_state;
        n_in    = r_in;
        n_res   = r_res;
        n_idx   = r_idx;
        n_hit   = r_hit;
        n_k     = r_k;
        n_need  = r_need;
        n_found = r_found;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_we    = 1'b0;
        o_waddr = r_idx[IW-1:0];
        o_wdata = '0;
        o_raddr = r_idx[IW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                // one entry a cycle; entry 0 becomes the whole free pool
                o_we = 1'b1;
                o_wdata = (r_idx == '0) ? ENTRY_W'({2'b11, 5'(POOL_ORDER)}) : '0;
                n_idx = r_idx + 1'b1;
                if (n_idx[IW]) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_in  = i_in_data;
                    n_res = '{status: ST_DONE, data_address: '0};
                    n_state = (i_in_data.op == OP_ALLOC) ? S_ORDER : S_REL_RD;
                end
            end
            S_ORDER: begin
                if (r_in.request_bytes == '0 ||
                    25'(r_in.request_bytes) > (25'd1 << POOL_ORDER)) begin
                    n_res.status = ST_REJECT;
                    n_state = S_DONE;
                end else if (!calc_ok) begin
                    n_res.status = ST_NOMEM;
                    n_state = S_DONE;
                end else begin
                    n_need  = calc_ord;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (r_idx[IW]) begin
                    if (r_found) begin
                        n_state = S_SPLIT;
                    end else begin
                        n_res.status = ST_NOMEM;
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_SCAN_CK;
                end
            end
            S_SCAN_CK: begin
                // blocks tile the pool, so hop from head to head
                n_idx   = r_idx + e_step;
                n_state = S_SCAN_RD;
                if (e_head && e_free && e_ord >= r_need && (!r_found || e_ord < r_k)) begin
                    n_hit   = r_idx[IW-1:0];
                    n_k     = e_ord;
                    n_found = 1'b1;
                    if (e_ord == r_need) begin
                        n_state = S_SPLIT;
                    end
                end
            end
            S_SPLIT: begin
                o_we = 1'b1;
                if (r_k > r_need) begin
                    n_k = r_k - 1'b1;
                    o_waddr = r_hit + IW'((one_w << (n_k - 5'(GRAIN_ORDER))));
                    o_wdata = {2'b11, n_k};
                end else begin
                    o_waddr = r_hit;
                    o_wdata = {2'b10, r_need};
                    n_res.data_address = data_addr[15:0];
                    n_state = S_DONE;
                end
            end
            S_REL_RD: begin
                n_idx = {1'b0, off[GRAIN_ORDER +: IW]};
                o_raddr = off[GRAIN_ORDER +: IW];
                if (25'(r_in.release_address) < 25'(HEADER_BYTES) ||
                    off[GRAIN_ORDER-1:0] != '0 || (off >> POOL_ORDER) != '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_REL_CK;
                end
            end
            S_REL_CK: begin
                if (!e_head || e_free) begin
                    n_state = S_DONE;
                end else begin
                    n_k = e_ord;
                    n_state = S_BUD_RD;
                end
            end
            S_BUD_RD: begin
                o_raddr = bidx;
                n_state = (r_k >= 5'(POOL_ORDER)) ? S_MARK : S_BUD_CK;
            end
            S_BUD_CK: begin
                if (e_head && e_free && e_ord == r_k) begin
                    o_we = 1'b1;
                    if (bidx < r_idx[IW-1:0]) begin
                        o_waddr = r_idx[IW-1:0];
                        n_idx = {1'b0, bidx};
                    end else begin
                        o_waddr = bidx;
                    end
                    n_k = r_k + 1'b1;
                    n_state = S_BUD_RD;
                end else begin
                    n_state = S_MARK;
                end
            end
            S_MARK: begin
                o_we = 1'b1;
                o_wdata = {2'b11, r_k};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_free) begin
                    o_res_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_res_data = r_res;

endmodule

// ===== design/buddy_block_allocator.sv =====
// Top level of the buddy block allocator: table RAM, sequencer, output register.
// Depends on bba_pkg, bba_ram and bba_ctrl.
`timescale 1ns / 1ps

// Binary buddy allocator over a 2^POOL_ORDER-byte pool, tracked per grain of
// 2^GRAIN_ORDER bytes in one table RAM (one 7-bit entry per grain: head,
// free, order). After reset a clearing pass that writes every table entry
// initializes the table; no transfer is accepted until it ends.
// One item is in work at a time. An allocate scans the table block by block
// (the scan hops head to head, lowest address first), then splits the block
// it found; a release checks its block, then merges with its buddy level by
// level. The table RAM has a single registered read port. Results sit in an
// output register, so a new item is taken while the previous result waits
// for its transfer.

module buddy_block_allocator import bba_pkg::*; #(
    parameter int POOL_ORDER   = POOL_ORDER_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int GRAIN_ORDER  = GRAIN_ORDER_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_bba_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_bba_out o_out_data
);

    localparam int IW = POOL_ORDER - GRAIN_ORDER;

    logic               we;
    logic [IW-1:0]      waddr, raddr;
    logic [ENTRY_W-1:0] wdata, rdata;
    logic               res_valid, res_free;
    t_bba_out           res_data;

    logic     r_out_valid;
    t_bba_out r_out_data;

    // output slot is free when empty or being drained this cycle
    assign res_free = !r_out_valid || i_out_ready;

    bba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (1 << IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    bba_ctrl #(
        .POOL_ORDER   (POOL_ORDER),
        .HEADER_BYTES (HEADER_BYTES),
        .GRAIN_ORDER  (GRAIN_ORDER)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_res_valid (res_valid),
        .i_res_free  (res_free),
        .o_res_data  (res_data),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid) begin
            r_out_data <= res_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== test/tb_buddy_block_allocator.sv =====
// Testbench for buddy_block_allocator: directed table plus random alloc/release traffic,
// checked against an in-bench buddy allocator model. Depends on bba_pkg and the design.
`timescale 1ns / 1ps

module tb_buddy_block_allocator;
    import bba_pkg::*;

    localparam int POOL_ORDER   = POOL_ORDER_DEF;
    localparam int HEADER_BYTES = HEADER_BYTES_DEF;
    localparam int GRAIN_ORDER  = GRAIN_ORDER_DEF;
    localparam int DEPTH        = 1 << (POOL_ORDER - GRAIN_ORDER);
    localparam longint POOL_BYTES = 64'd1 << POOL_ORDER;
    localparam int N_RANDOM     = 630;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_ready;
    t_bba_in  i_in_data = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_bba_out o_out_data;

    buddy_block_allocator #(
        .POOL_ORDER(POOL_ORDER), .HEADER_BYTES(HEADER_BYTES), .GRAIN_ORDER(GRAIN_ORDER)
    ) i_dut (.*);

    always #1 i_clk = ~i_clk;

    // Shadow block table: head, free, order per grain.
    logic [6:0] grain_map [DEPTH];
    t_bba_out   pending_results [$];
    int         error_count = 0;
    bit         no_idle = 0;
    bit         hold_off = 0;
    logic [15:0] live_addrs [$];

    // Directed rows: expected result typed in where obvious, else predicted.
    typedef struct {
        logic        op;
        logic [16:0] req;
        logic [15:0] rel;
        bit          has_exp;
        t_bba_out    exp;
    } t_row;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic void reset_map();
        foreach (grain_map[i]) grain_map[i] = '0;
        grain_map[0] = {1'b1, 1'b1, 5'(POOL_ORDER)};
    endfunction

    function automatic bit is_free_head(input logic [6:0] e, input int ord);
        return e[HEAD_POS] && e[FREE_POS] && (int'(e[4:0]) == ord);
    endfunction

    function automatic t_bba_out allocate_block(input longint req);
        t_bba_out r;
        longint need;
        int ord, k, hit;
        bit found;
        r = '0;
        found = 0;
        hit = 0;
        if (req == 0 || req > POOL_BYTES) begin
            r.status = ST_REJECT;
            return r;
        end
        need = req + HEADER_BYTES;
        ord = GRAIN_ORDER;
        while (ord <= POOL_ORDER && (64'd1 << ord) < need) ord++;
        if (ord > POOL_ORDER) begin
            r.status = ST_NOMEM;
            return r;
        end
        for (k = ord; k <= POOL_ORDER && !found; k++)
            for (int i = 0; i < DEPTH && !found; i++)
                if (is_free_head(grain_map[i], k)) begin
                    hit = i;
                    found = 1;
                end
        if (!found) begin
            r.status = ST_NOMEM;
            return r;
        end
        k = grain_map[hit][4:0];
        while (k > ord) begin
            k--;
            grain_map[(((longint'(hit) << GRAIN_ORDER) + (64'd1 << k)) >> GRAIN_ORDER)
                      % DEPTH] = {2'b11, 5'(k)};
        end
        grain_map[hit] = {2'b10, 5'(ord)};
        r.status = ST_DONE;
        r.data_address = 16'((longint'(hit) << GRAIN_ORDER) + HEADER_BYTES);
        return r;
    endfunction

    function automatic void release_block(input longint addr);
        longint off, buddy;
        int idx, bidx, ord;
        logic [6:0] e;
        if (addr < HEADER_BYTES) return;
        off = addr - HEADER_BYTES;
        if ((off & ((64'd1 << GRAIN_ORDER) - 1)) != 0 || off >= POOL_BYTES) return;
        idx = int'(off >> GRAIN_ORDER);
        e = grain_map[idx];
        if (!e[HEAD_POS] || e[FREE_POS]) return;
        ord = e[4:0];
        while (ord < POOL_ORDER) begin
            buddy = off ^ (64'd1 << ord);
            bidx = int'(buddy >> GRAIN_ORDER);
            if (!is_free_head(grain_map[bidx], ord)) break;
            if (buddy < off) begin
                grain_map[idx] = '0;
                off = buddy;
                idx = bidx;
            end else begin
                grain_map[bidx] = '0;
            end
            ord++;
        end
        grain_map[idx] = {2'b11, 5'(ord)};
    endfunction

    function automatic t_bba_out predict_result(input t_bba_in item);
        t_bba_out r;
        r = '0;
        if (item.op == OP_ALLOC) r = allocate_block(item.request_bytes);
        else release_block(item.release_address);
        return r;
    endfunction

    // Drive one transfer and record its predicted result; with random gaps first.
    task automatic send_item(input t_bba_in item, input bit has_exp, input t_bba_out exp);
        t_bba_out p;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        p = predict_result(item);
        if (has_exp && p != exp)
            report_mismatch("directed row vs model", p, exp);
        pending_results.push_back(p);
        if (item.op == OP_ALLOC && p.status == ST_DONE) live_addrs.push_back(p.data_address);
    endtask

    // Output side: random stalls, optional long hold-off, in-order compare.
    always @(posedge i_clk) begin
        t_bba_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_out_data, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status != want.status)
                    report_mismatch("status", o_out_data.status, want.status);
                if (o_out_data.data_address != want.data_address)
                    report_mismatch("data_address", o_out_data.data_address,
                                    want.data_address);
            end
        end
    end

    initial begin : sink_proc
        int gap;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
            if (!no_idle && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 4);
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        #10ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stim_proc
        t_row rows [$];
        t_row row;
        t_bba_in item;
        t_bba_out none;
        int wait_cycles;
        int idx;
        none = '0;
        reset_map();
        // Directed table.
        rows.push_back('{OP_ALLOC, 17'd0, 16'd0, 1, '{ST_REJECT, 16'd0}});
        rows.push_back('{OP_ALLOC, 17'h1FFFF, 16'd0, 1, '{ST_REJECT, 16'd0}});
        rows.push_back('{OP_ALLOC, 17'd65537, 16'd0, 1, '{ST_REJECT, 16'd0}});
        rows.push_back('{OP_ALLOC, 17'd65536, 16'd0, 1, '{ST_NOMEM, 16'd0}});
        rows.push_back('{OP_ALLOC, 17'd65504, 16'd0, 1, '{ST_DONE, 16'd32}});
        rows.push_back('{OP_ALLOC, 17'd1, 16'd0, 1, '{ST_NOMEM, 16'd0}});
        rows.push_back('{OP_RELEASE, 17'd0, 16'd32, 1, '{ST_DONE, 16'd0}});
        rows.push_back('{OP_RELEASE, 17'd0, 16'd32, 1, none});       // already free
        rows.push_back('{OP_ALLOC, 17'd1, 16'd0, 1, '{ST_DONE, 16'd32}}); // tiny
        rows.push_back('{OP_ALLOC, 17'd32, 16'd0, 0, none});
        rows.push_back('{OP_ALLOC, 17'd33, 16'd0, 0, none});
        rows.push_back('{OP_ALLOC, 17'd1000, 16'd0, 0, none});
        rows.push_back('{OP_RELEASE, 17'h1FFFF, 16'd0, 1, none});    // below header
        rows.push_back('{OP_RELEASE, 17'd0, 16'd33, 1, none});       // off grain
        rows.push_back('{OP_RELEASE, 17'd0, 16'hFFFF, 1, none});
        rows.push_back('{OP_RELEASE, 17'd0, 16'd224, 1, none});      // not a head
        rows.push_back('{OP_RELEASE, 17'd0, 16'd96, 0, none});
        rows.push_back('{OP_RELEASE, 17'd0, 16'd32, 0, none});
        rows.push_back('{OP_ALLOC, 17'd4000, 16'd0, 0, none});
        rows.push_back('{OP_ALLOC, 17'd20000, 16'd0, 0, none});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) begin
            row = rows[r];
            item = '{row.op, row.req, row.rel};
            send_item(item, row.has_exp, row.exp);
        end

        // Random part: mostly valid allocs/releases, some noise.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 150) hold_off = 1;
            if (n == N_RANDOM - 80) no_idle = 1;
            item = '0;
            case ($urandom_range(0, 9)) inside
                [0:3]: begin
                    item.op = OP_ALLOC;
                    item.request_bytes = ($urandom_range(0, 3) == 0)
                        ? 17'($urandom_range(1, 8000)) : 17'($urandom_range(1, 500));
                end
                [4:7]: begin
                    item.op = OP_RELEASE;
                    if (live_addrs.size() > 0) begin
                        idx = $urandom_range(0, live_addrs.size() - 1);
                        item.release_address = live_addrs[idx];
                        live_addrs.delete(idx);
                    end else begin
                        item.release_address = 16'($urandom);
                    end
                end
                8: begin
                    item.op = OP_ALLOC;
                    item.request_bytes = 17'($urandom);
                end
                default: begin
                    item.op = OP_RELEASE;
                    item.request_bytes = 17'($urandom);
                    item.release_address = 16'($urandom);
                end
            endcase
            send_item(item, 0, none);
        end
        i_in_valid <= 1'b0;

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/bba_pkg.sv
design/bba_ram.sv
design/bba_ctrl.sv
design/buddy_block_allocator.sv
test/tb_buddy_block_allocator.sv
